// File: sv/ncdf_pkg.sv
// ncdf_pkg: shared constants and types for the normal cdf core
// fixed-point formats, approximation coefficients and register indexes
// no dependencies
package ncdf_pkg;

    // internal fraction bits of every working value
    localparam int QF = 30;
    localparam logic [63:0] QONE = 64'd1 << QF;
    localparam logic [63:0] QHALF = 64'd1 << (QF - 1);

    // magnitudes rounded to nearest q30
    localparam logic [31:0] MAG_A1 = 32'(((64'd254829592 << QF) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A2 = 32'(((64'd284496736 << QF) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A3 = 32'(((64'd1421413741 << QF) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A4 = 32'(((64'd1453152027 << QF) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A5 = 32'(((64'd1061405429 << QF) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] COEF_P = 32'(((64'd3275911 << QF) + 64'd5000000) / 64'd10000000);

    localparam logic signed [33:0] COEF_A1 = $signed({2'b00, MAG_A1});
    localparam logic signed [33:0] COEF_A2 = -$signed({2'b00, MAG_A2});
    localparam logic signed [33:0] COEF_A3 = $signed({2'b00, MAG_A3});
    localparam logic signed [33:0] COEF_A4 = -$signed({2'b00, MAG_A4});
    localparam logic signed [33:0] COEF_A5 = $signed({2'b00, MAG_A5});

    // constant added after each horner multiply, last step adds nothing
    localparam int HORNER_STEPS = 5;
    localparam logic signed [33:0] HORNER_ADD [HORNER_STEPS] =
        '{COEF_A4, COEF_A3, COEF_A2, COEF_A1, 34'sd0};

    localparam logic [29:0] INV_SQRT2 = 30'd759250125;
    localparam logic [29:0] LN2 = 30'd744261118;

    // taylor terms of exp(-r)
    localparam int EXP_TERMS = 12;

    typedef enum logic {
        REG_MEAN    = 1'b0,
        REG_STD_DEV = 1'b1
    } reg_idx_t;

endpackage

// File: sv/ncdf_stream_if.sv
// ncdf_sample_if / ncdf_prob_if: valid-ready item channels of the core
// depends on nothing
interface ncdf_sample_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ncdf_prob_if #(parameter int FRAC_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   probability;
    modport source (output valid, output probability, input ready);
    modport sink   (input valid, input probability, output ready);
endinterface

// File: sv/ncdf_div_pipe.sv
// ncdf_div_pipe: pipelined restoring divider, one quotient bit per stage
// sideband bits travel alongside; no package needed
module ncdf_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);
    logic          stg_valid [QW+1];
    logic [DW-1:0] stg_rem   [QW+1];
    logic [QW-1:0] stg_num   [QW+1];
    logic [DW-1:0] stg_div   [QW+1];
    logic [QW-1:0] stg_quo   [QW+1];
    logic [SW-1:0] stg_side  [QW+1];

    assign stg_valid[0] = in_valid;
    assign stg_rem[0]   = in_rem;
    assign stg_num[0]   = in_num;
    assign stg_div[0]   = in_div;
    assign stg_quo[0]   = '0;
    assign stg_side[0]  = in_side;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic          valid_reg;
        logic [DW-1:0] rem_reg, rem_next;
        logic [QW-1:0] num_reg;
        logic [DW-1:0] div_reg;
        logic [QW-1:0] quo_reg, quo_next;
        logic [SW-1:0] side_reg;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        always_comb
        begin
            trial    = {stg_rem[i], stg_num[i][QW-1]};
            diff     = trial - {1'b0, stg_div[i]};
            ge       = trial >= {1'b0, stg_div[i]};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {stg_quo[i][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= stg_valid[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                num_reg  <= {stg_num[i][QW-2:0], 1'b0};
                div_reg  <= stg_div[i];
                quo_reg  <= quo_next;
                side_reg <= stg_side[i];
            end
        end

        assign stg_valid[i+1] = valid_reg;
        assign stg_rem[i+1]   = rem_reg;
        assign stg_num[i+1]   = num_reg;
        assign stg_div[i+1]   = div_reg;
        assign stg_quo[i+1]   = quo_reg;
        assign stg_side[i+1]  = side_reg;
    end

    assign out_valid = stg_valid[QW];
    assign out_quo   = stg_quo[QW];
    assign out_side  = stg_side[QW];
endmodule

// File: sv/ncdf_exp_pipe.sv
// ncdf_exp_pipe: exp(-s) in q30 by ln2 range reduction and a taylor series
// depends on ncdf_pkg
module ncdf_exp_pipe (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [33:0] s,
    output logic        out_valid,
    output logic [30:0] e
);
    import ncdf_pkg::*;

    localparam int NB = 5;

    // range reduction, one bit of n per stage
    logic        rv_s [NB+1];
    logic [33:0] rg_s [NB+1];
    logic [4:0]  rn_s [NB+1];

    assign rv_s[0] = in_valid;
    assign rg_s[0] = s;
    assign rn_s[0] = '0;

    for (genvar j = 0; j < NB; j++) begin : g_red
        localparam int B = NB - 1 - j;
        localparam logic [33:0] LNK = 34'({4'b0, LN2} << B);
        logic        valid_reg;
        logic [33:0] g_reg;
        logic [4:0]  n_reg;
        logic        ge;

        assign ge = rg_s[j] >= LNK;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= rv_s[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                g_reg <= ge ? rg_s[j] - LNK : rg_s[j];
                n_reg <= rn_s[j] | (5'(ge) << B);
            end
        end

        assign rv_s[j+1] = valid_reg;
        assign rg_s[j+1] = g_reg;
        assign rn_s[j+1] = n_reg;
    end

    // taylor series in horner form, two stages per term
    logic        tv_s [EXP_TERMS+1];
    logic [29:0] tg_s [EXP_TERMS+1];
    logic [4:0]  tn_s [EXP_TERMS+1];
    logic [30:0] tr_s [EXP_TERMS+1];

    assign tv_s[0] = rv_s[NB];
    assign tg_s[0] = rg_s[NB][29:0];
    assign tn_s[0] = rn_s[NB];
    assign tr_s[0] = QONE[30:0];

    for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
        localparam int K = EXP_TERMS - j;
        localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / K);
        logic        va_reg, vb_reg;
        logic [29:0] ga_reg, gb_reg;
        logic [4:0]  na_reg, nb_reg;
        logic [30:0] m_reg;
        logic [30:0] r_reg;
        logic [60:0] prod;
        logic [61:0] prod_rnd;
        logic [30:0] quo;

        assign prod     = tg_s[j] * tr_s[j];
        assign prod_rnd = {1'b0, prod} + 62'(QHALF);

        if (K == 1) begin : g_unit
            assign quo = m_reg;
        end
        else begin : g_recip
            logic [63:0] est_full;
            logic [30:0] est;
            logic [34:0] est_k;
            logic [34:0] rem;

            always_comb
            begin
                est_full = 64'(m_reg) * 64'(RECIP);
                est      = est_full[62:32];
                est_k    = 35'(est) * 35'(K);
                rem      = 35'(m_reg) - est_k;
                quo      = (rem >= 35'(K)) ? est + 31'd1 : est;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end
            else if (en)
            begin
                va_reg <= tv_s[j];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg  <= prod_rnd[60:30];
                ga_reg <= tg_s[j];
                na_reg <= tn_s[j];
                r_reg  <= QONE[30:0] - quo;
                gb_reg <= ga_reg;
                nb_reg <= na_reg;
            end
        end

        assign tv_s[j+1] = vb_reg;
        assign tg_s[j+1] = gb_reg;
        assign tn_s[j+1] = nb_reg;
        assign tr_s[j+1] = r_reg;
    end

    // scale by 2^-n with rounding
    logic        valid_reg;
    logic [30:0] e_reg;
    logic [31:0] half_shift;
    logic [31:0] rounded;

    always_comb
    begin
        half_shift = {tr_s[EXP_TERMS], 1'b0} >> tn_s[EXP_TERMS];
        rounded    = (half_shift + 32'd1) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tv_s[EXP_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= (tn_s[EXP_TERMS] == 5'd0) ? tr_s[EXP_TERMS] : rounded[30:0];
        end
    end

    assign out_valid = valid_reg;
    assign e         = e_reg;
endmodule

// File: sv/ncdf_poly_pipe.sv
// ncdf_poly_pipe: horner polynomial in t, product with exp and output rounding
// depends on ncdf_pkg
module ncdf_poly_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [30:0]        t,
    input  logic [30:0]        e,
    input  logic               neg,
    output logic               out_valid,
    output logic [FRAC_BITS:0] probability
);
    import ncdf_pkg::*;

    logic               hv_s [HORNER_STEPS+1];
    logic signed [33:0] hy_s [HORNER_STEPS+1];
    logic [30:0]        ht_s [HORNER_STEPS+1];
    logic [30:0]        he_s [HORNER_STEPS+1];
    logic               hn_s [HORNER_STEPS+1];

    assign hv_s[0] = in_valid;
    assign hy_s[0] = COEF_A5;
    assign ht_s[0] = t;
    assign he_s[0] = e;
    assign hn_s[0] = neg;

    // product rounded half away from zero, then the next coefficient
    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
        logic               valid_reg;
        logic signed [33:0] y_reg;
        logic [30:0]        t_reg;
        logic [30:0]        e_reg;
        logic               neg_reg;
        logic [33:0]        mag;
        logic [64:0]        prod;
        logic [64:0]        prod_rnd;
        logic signed [35:0] term;
        logic signed [35:0] sum;

        always_comb
        begin
            mag      = hy_s[j][33] ? 34'(-hy_s[j]) : 34'(hy_s[j]);
            prod     = 65'(mag) * 65'(ht_s[j]);
            prod_rnd = prod + 65'(QHALF);
            term     = $signed({1'b0, prod_rnd[64:30]});
            if (hy_s[j][33])
            begin
                term = -term;
            end
            sum = term + 36'(HORNER_ADD[j]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= hv_s[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg   <= sum[33:0];
                t_reg   <= ht_s[j];
                e_reg   <= he_s[j];
                neg_reg <= hn_s[j];
            end
        end

        assign hv_s[j+1] = valid_reg;
        assign hy_s[j+1] = y_reg;
        assign ht_s[j+1] = t_reg;
        assign he_s[j+1] = e_reg;
        assign hn_s[j+1] = neg_reg;
    end

    logic               valid_reg;
    logic [FRAC_BITS:0] prob_reg;
    logic [30:0]        y_clamp;
    logic [61:0]        ye_prod;
    logic [62:0]        ye_rnd;
    logic [32:0]        ye;
    logic [32:0]        p2;
    logic [32:0]        res;
    logic signed [33:0] y_fin;

    always_comb
    begin
        y_fin = hy_s[HORNER_STEPS];
        if (y_fin < 34'sd0)
        begin
            y_clamp = '0;
        end
        else if (y_fin > $signed(34'(QONE)))
        begin
            y_clamp = QONE[30:0];
        end
        else
        begin
            y_clamp = y_fin[30:0];
        end
        ye_prod = 62'(y_clamp) * 62'(he_s[HORNER_STEPS]);
        ye_rnd  = {1'b0, ye_prod} + 63'(QHALF);
        ye      = ye_rnd[62:30];
        if (ye > 33'(QONE))
        begin
            ye = 33'(QONE);
        end
        // one minus or one plus erf, 30 fraction bits
        p2  = hn_s[HORNER_STEPS] ? ye : 33'(QONE << 1) - ye;
        res = (p2 + (33'd1 << (QF - FRAC_BITS))) >> (QF + 1 - FRAC_BITS);
        if (res > (33'd1 << FRAC_BITS))
        begin
            res = 33'd1 << FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= hv_s[HORNER_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prob_reg <= res[FRAC_BITS:0];
        end
    end

    assign out_valid   = valid_reg;
    assign probability = prob_reg;
endmodule

// File: sv/normal_cdf_erf_approx_core.sv
// normal_cdf_erf_approx_core: streaming normal cdf via the 7.1.26 erf approximation
// depends on ncdf_pkg, ncdf_stream_if, ncdf_div_pipe, ncdf_exp_pipe, ncdf_poly_pipe
//
//   channel    dir   handshake      payload
//   sample_ch  in    valid/ready    sample       signed q15.16
//   prob_ch    out   valid/ready    probability  unsigned q1.FRAC_BITS
//   apb        in    psel/penable   mean at 0x0, std_dev at 0x4
//
// one item per cycle enters while the output is not stalled
// most of the pipeline depth lies in the two bit-per-stage dividers (34 and 31 stages)
// rst_n clears all valid bits and loads mean = 0, std_dev = 1.0
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
module normal_cdf_erf_approx_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ncdf_sample_if.sink sample_ch,
    ncdf_prob_if.source prob_ch
);
    import ncdf_pkg::*;

    // configuration registers
    logic [31:0] mean_reg;
    logic [30:0] std_dev_reg;
    reg_idx_t    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            std_dev_reg <= 31'd65536;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_MEAN:    mean_reg <= pwdata;
                REG_STD_DEV: std_dev_reg <= pwdata[30:0];
                default:     mean_reg <= mean_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MEAN:    prdata = mean_reg;
            REG_STD_DEV: prdata = {1'b0, std_dev_reg};
            default:     prdata = '0;
        endcase
    end

    // the whole pipeline moves together unless the output is full and held
    logic en;

    assign en              = !prob_ch.valid || prob_ch.ready;
    assign sample_ch.ready = en;

    // stage 0: deviation magnitude, sign and divisor
    logic signed [32:0] dev;
    logic               dev_neg;
    logic [32:0]        dev_abs;
    logic [30:0]        sig;

    always_comb
    begin
        dev     = $signed({sample_ch.sample[31], sample_ch.sample})
                - $signed({mean_reg[31], mean_reg});
        dev_neg = dev[32];
        dev_abs = dev_neg ? 33'(-dev) : 33'(dev);
        sig     = (std_dev_reg == '0) ? 31'd1 : std_dev_reg;
    end

    logic        s0_valid_reg;
    logic [32:0] ad_reg;
    logic [30:0] sig_reg;
    logic        s0_neg_reg;
    logic        ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad_reg     <= dev_abs;
            sig_reg    <= sig;
            s0_neg_reg <= dev_neg;
        end
    end

    // quotient beyond 34 bits is far past the 8.0 clamp
    assign ovf = {2'b00, ad_reg[32:4]} >= sig_reg;

    // |d| / sigma in q30, one bit per stage
    logic        q_valid;
    logic [33:0] q_quo;
    logic [1:0]  q_side;

    ncdf_div_pipe #(
        .DW (31),
        .QW (34),
        .SW (2)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_rem    (ovf ? 31'd0 : {2'b00, ad_reg[32:4]}),
        .in_num    ({ad_reg[3:0], 30'd0}),
        .in_div    (sig_reg),
        .in_side   ({ovf, s0_neg_reg}),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_side  (q_side)
    );

    // clamp to 8.0, scale by 1/sqrt2 and hold |z| below 4.0
    logic [33:0] q_clamp;
    logic [63:0] az_prod;
    logic [64:0] az_rnd;
    logic [31:0] az;

    always_comb
    begin
        q_clamp = (q_side[1] || q_quo > 34'(QONE << 3)) ? 34'(QONE << 3) : q_quo;
        az_prod = 64'(q_clamp) * 64'(INV_SQRT2);
        az_rnd  = {1'b0, az_prod} + 65'(QHALF);
        az      = (az_rnd[64:62] != '0) ? 32'hFFFF_FFFF : az_rnd[61:30];
    end

    logic        az_valid_reg;
    logic [31:0] az_reg;
    logic        az_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            az_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg     <= az;
            az_neg_reg <= q_side[0];
        end
    end

    // 1 + p|z| for the reciprocal, and s = z^2 for the exponential
    logic [63:0] pz_prod;
    logic [63:0] pz_rnd;
    logic [63:0] sq_prod;
    logic [64:0] sq_rnd;

    always_comb
    begin
        pz_prod = 64'(COEF_P) * 64'(az_reg);
        pz_rnd  = pz_prod + QHALF;
        sq_prod = 64'(az_reg) * 64'(az_reg);
        sq_rnd  = {1'b0, sq_prod} + 65'(QHALF);
    end

    logic        p_valid_reg;
    logic [31:0] den_reg;
    logic [33:0] s_reg;
    logic        p_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= az_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg   <= QONE[31:0] + pz_rnd[61:30];
            s_reg     <= sq_rnd[63:30];
            p_neg_reg <= az_neg_reg;
        end
    end

    // t = 2^60 / den rounded; the 2^60 bit alone seeds the remainder
    logic        t_valid;
    logic [30:0] t_quo;
    logic        t_neg;

    ncdf_div_pipe #(
        .DW (32),
        .QW (31),
        .SW (1)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .in_rem    (32'd1 << (QF - 1)),
        .in_num    (den_reg[31:1]),
        .in_div    (den_reg),
        .in_side   (p_neg_reg),
        .out_valid (t_valid),
        .out_quo   (t_quo),
        .out_side  (t_neg)
    );

    // exp(-s) runs beside the reciprocal; the delay register below brings it into step
    logic        e_valid;
    logic [30:0] e_val;

    ncdf_exp_pipe u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .s         (s_reg),
        .out_valid (e_valid),
        .e         (e_val)
    );

    logic        e_valid_dly_reg;
    logic [30:0] e_dly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_dly_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_dly_reg <= e_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_dly_reg <= e_val;
        end
    end

    // polynomial, erf and final rounding; its last register is the output
    ncdf_poly_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (t_valid),
        .t           (t_quo),
        .e           (e_dly_reg),
        .neg         (t_neg),
        .out_valid   (prob_ch.valid),
        .probability (prob_ch.probability)
    );

`ifndef SYNTHESIS
    // exponential and reciprocal branches stay in step
    assert property (@(posedge clk) disable iff (!rst_n)
        t_valid == e_valid_dly_reg)
        else $error("exp and reciprocal branches out of step");

    // reciprocal of a value at least one never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        t_valid |-> (64'(t_quo) <= QONE))
        else $error("reciprocal above one");

    // probability never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        prob_ch.valid |-> (33'(prob_ch.probability) <= (33'd1 << FRAC_BITS)))
        else $error("probability above one");
`endif
endmodule

// File: dv/ncdf_prob_checker.sv
// ncdf_prob_checker: watches both item channels of the normal cdf core,
// predicts each probability and compares in order
// depends on ncdf_pkg
`timescale 1ns / 1ps

module ncdf_prob_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  logic [31:0] sample,
    input  logic        prob_valid,
    input  logic        prob_ready,
    input  logic [FRAC_BITS:0] probability,
    input  logic [31:0] mean_q,
    input  logic [30:0] std_dev_q,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import ncdf_pkg::*;

    logic [FRAC_BITS:0] expected_probs [$];

    // rounded q30 product, sign handled on magnitudes
    function automatic longint q30_mul(longint a, longint b);
        bit neg;
        logic [63:0] ua, ub, m;
        begin
            neg = (a < 0) != (b < 0);
            ua = a < 0 ? -a : a;
            ub = b < 0 ? -b : b;
            m = (ua * ub + QHALF) >> QF;
            return neg ? -longint'(m) : longint'(m);
        end
    endfunction

    function automatic logic [63:0] exp_neg_q30(logic [63:0] s);
        logic [63:0] n, g, r;
        begin
            n = s / LN2;
            g = s - n * LN2;
            r = QONE;
            for (int k = EXP_TERMS; k >= 1; k--)
                r = QONE - (((g * r + QHALF) >> QF) / k);
            if (n == 0)
                return r;
            if (n > 40)
                return 0;
            return (r + (64'd1 << (n - 1))) >> n;
        end
    endfunction

    function automatic logic [FRAC_BITS:0] cdf_of(logic [31:0] x, logic [31:0] mu,
                                                   logic [30:0] sd);
        longint d, y;
        bit neg;
        logic [63:0] ad, sig, q, az, den, t, s, e, ye, erfv, p2, res;
        begin
            d = longint'($signed(x)) - longint'($signed(mu));
            neg = d < 0;
            ad = neg ? -d : d;
            sig = (sd == 0) ? 64'd1 : 64'(sd);
            q = (ad << QF) / sig;
            if (q > 8 * QONE)
                q = 8 * QONE;
            az = (q * INV_SQRT2 + QHALF) >> QF;
            if (az >= 4 * QONE)
                az = 4 * QONE - 1;
            den = QONE + ((64'(COEF_P) * az + QHALF) >> QF);
            t = ((QONE << QF) + (den >> 1)) / den;
            y = longint'(COEF_A5);
            for (int i = 0; i < HORNER_STEPS; i++)
                y = q30_mul(y, longint'(t)) + longint'(HORNER_ADD[i]);
            if (y < 0)
                y = 0;
            if (y > longint'(QONE))
                y = QONE;
            s = (az * az + QHALF) >> QF;
            e = exp_neg_q30(s);
            ye = (64'(y) * e + QHALF) >> QF;
            if (ye > QONE)
                ye = QONE;
            erfv = QONE - ye;
            p2 = neg ? QONE - erfv : QONE + erfv;
            res = (p2 + (64'd1 << (QF - FRAC_BITS))) >> (QF + 1 - FRAC_BITS);
            if (res > (64'd1 << FRAC_BITS))
                res = 64'd1 << FRAC_BITS;
            return res[FRAC_BITS:0];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            result_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                expected_probs.push_back(cdf_of(sample, mean_q, std_dev_q));
            if (prob_valid && prob_ready)
            begin
                result_count <= result_count + 1;
                if (expected_probs.size() == 0)
                begin
                    $error("probability %0d with no item outstanding", probability);
                    fail_count <= fail_count + 1;
                end
                else if (expected_probs[0] !== probability)
                begin
                    $error("probability: expected %0d actual %0d",
                           expected_probs[0], probability);
                    fail_count <= fail_count + 1;
                    void'(expected_probs.pop_front());
                end
                else
                    void'(expected_probs.pop_front());
            end
            pending_count <= expected_probs.size();
        end
    end
endmodule

// File: dv/tb_normal_cdf_erf_approx_core.sv
// tb_normal_cdf_erf_approx_core: stimulus, apb register writes and verdict
// for the normal cdf core; checking lives in ncdf_prob_checker
`timescale 1ns / 1ps

module tb_normal_cdf_erf_approx_core;
    import ncdf_pkg::*;

    localparam int LATENCY = 74;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ncdf_sample_if sample_ch ();
    ncdf_prob_if #(.FRAC_BITS(16)) prob_ch ();

    // shadow copy of the registers, handed to the checker
    logic [31:0] mean_q;
    logic [30:0] std_dev_q;
    int fail_count, pending_count, result_count;

    // idling percentages, and a long receiver hold-off on request
    int send_idle_pct, recv_idle_pct;
    int hold_off_cycles;
    int sent_items;

    normal_cdf_erf_approx_core #(.FRAC_BITS(16)) DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_ch(sample_ch.sink), .prob_ch(prob_ch.source)
    );

    ncdf_prob_checker #(.FRAC_BITS(16)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_ch.valid), .sample_ready(sample_ch.ready),
        .sample(sample_ch.sample),
        .prob_valid(prob_ch.valid), .prob_ready(prob_ch.ready),
        .probability(prob_ch.probability),
        .mean_q(mean_q), .std_dev_q(std_dev_q),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        prob_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                prob_ch.ready <= 0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else
                prob_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // apb write: setup cycle, then access cycle; idle-only
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        begin
            @(posedge clk);
            psel <= 1;
            penable <= 0;
            pwrite <= 1;
            paddr <= 3'(idx) << 2;
            pwdata <= value;
            @(posedge clk);
            penable <= 1;
            @(posedge clk);
            psel <= 0;
            penable <= 0;
            pwrite <= 0;
            if (idx == REG_MEAN)
                mean_q = value;
            else
                std_dev_q = value[30:0];
        end
    endtask

    // offer one item and hold it until accepted; idle gaps before it
    task automatic send_sample(logic [31:0] x);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                sample_ch.valid <= 0;
                @(posedge clk);
            end
            sample_ch.valid <= 1;
            sample_ch.sample <= x;
            do @(posedge clk); while (!sample_ch.ready);
            sent_items++;
            // the next call may offer its item at this same edge,
            // so valid stays high until a gap or a drain
        end
    endtask

    // wait until every expectation is met, then let the pipe settle
    task automatic drain();
        begin
            sample_ch.valid <= 0;
            while (pending_count != 0)
                @(posedge clk);
            repeat (LATENCY + 10) @(posedge clk);
        end
    endtask

    // a random sample: mostly within four sigma of the mean, else anything
    function automatic logic [31:0] pick_sample();
        longint off;
        begin
            case ($urandom_range(9))
                0, 1: return $urandom;
                2:    return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
                default:
                begin
                    off = longint'($urandom_range(8 * 65536)) - 4 * 65536;
                    off = off * longint'(std_dev_q) / 65536;
                    return 32'(longint'($signed(mean_q)) + off);
                end
            endcase
        end
    endfunction

    // one setting of mean and sigma, then a batch of items
    task automatic random_phase(logic [31:0] mu, logic [31:0] sd, int count);
        begin
            write_reg(REG_MEAN, mu);
            write_reg(REG_STD_DEV, sd);
            repeat (count) send_sample(pick_sample());
            drain();
        end
    endtask

    initial
    begin
        logic [31:0] directed [$];
        int phase;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        sample_ch.valid = 0;
        sample_ch.sample = 0;
        mean_q = 0;
        std_dev_q = 31'd65536;
        send_idle_pct = 35;
        recv_idle_pct = 52;
        hold_off_cycles = 0;
        sent_items = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed: reset settings, field extremes, zero deviation, tails
        directed = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                     32'h00010000, 32'hffff0000, 32'h00020000, 32'hfffe0000,
                     32'h00040000, 32'hfffc0000, 32'h00008000, 32'h55555555,
                     32'haaaaaaaa};
        foreach (directed[i])
            send_sample(directed[i]);
        drain();
        // zero sigma counts as one lsb; extreme mean
        write_reg(REG_STD_DEV, 32'h0);
        write_reg(REG_MEAN, 32'h80000000);
        send_sample(32'h80000000);
        send_sample(32'h80000001);
        send_sample(32'h7fffffff);
        drain();
        write_reg(REG_STD_DEV, 32'h7fffffff);
        write_reg(REG_MEAN, 32'h7fffffff);
        send_sample(32'h80000000);
        send_sample(32'h7fffffff);
        send_sample(32'h0);
        drain();

        // random phases across settings, three idling regimes
        for (phase = 0; phase < 9; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 35;
            end
            if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // long hold-off so the pipe fills and back-pressures
                hold_off_cycles = 300;
            end
            case (phase % 3)
                0: random_phase($urandom, 32'($urandom_range(32'h7fffffff, 1)), 180);
                1: random_phase(32'($urandom_range(65536 * 8)) - 32'd262144,
                                32'($urandom_range(65536 * 4, 256)), 180);
                default: random_phase($urandom_range(1) ? 32'h80000000 : 32'h7fffffff,
                                      $urandom_range(1) ? 32'h1 : 32'h7fffffff, 180);
            endcase
        end

        drain();
        $display("ran %0d items, %0d probabilities checked over a dozen register settings",
                 sent_items, result_count);
        $display("covered zero and extreme sigma, extreme mean and back-pressure");
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: files.f
sv/ncdf_pkg.sv
sv/ncdf_stream_if.sv
sv/ncdf_div_pipe.sv
sv/ncdf_exp_pipe.sv
sv/ncdf_poly_pipe.sv
sv/normal_cdf_erf_approx_core.sv
dv/ncdf_prob_checker.sv
dv/tb_normal_cdf_erf_approx_core.sv
